>>> sv/bfsa_pkg.sv
// Shared types, widths and codes of the best-fit segment allocator.
// Depends on nothing; every other file imports it.
package bfsa_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ADDR_BITS   = 20;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int KCNT_W      = IDX_W + 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int NGRP        = (MAX_ENTRIES + 3) / 4;

    localparam int MODE_W  = 3;
    localparam int ID_W    = 16;
    localparam int TIME_W  = 24;
    localparam int STAT_W  = 3;
    localparam int FREED_W = 5;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COMPACT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE,
        OP_TICK,
        OP_COMPACT,
        OP_QUERY,
        OP_NONE
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOFIT    = 3'd1,
        ST_DUP      = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        op_t                  op;
        logic [ID_W-1:0]      id;
        logic [ADDR_BITS-1:0] req;
        logic [TIME_W-1:0]    rt;
        logic [TIME_W-1:0]    tick;
    } cmd_t;

    typedef logic [MAX_ENTRIES-1:0][ADDR_BITS-1:0] addr_vec_t;

    typedef struct packed {
        logic                 any;
        logic [IDX_W-1:0]     idx;
        logic [ADDR_BITS-1:0] key;
    } amin_t;

endpackage

>>> sv/bfsa_intf.sv
// Handshake channel interfaces: configuration, request and result.
// Depends on bfsa_pkg.
interface bfsa_cfg_if import bfsa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bfsa_in_if import bfsa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [ID_W-1:0]      process_id;
    logic [ADDR_BITS-1:0] request_size;
    logic [TIME_W-1:0]    run_time;
    logic [TIME_W-1:0]    tick_amount;
    modport source (output valid, output mode, output process_id, output request_size,
                    output run_time, output tick_amount, input ready);
    modport sink (input valid, input mode, input process_id, input request_size,
                  input run_time, input tick_amount, output ready);
endinterface

interface bfsa_out_if import bfsa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STAT_W-1:0]    status;
    logic [ADDR_BITS-1:0] address;
    logic [ADDR_BITS-1:0] hole_size;
    logic [ADDR_BITS-1:0] free_memory;
    logic                 busy_res;
    logic [FREED_W-1:0]   freed_count;
    modport source (output valid, output status, output address, output hole_size,
                    output free_memory, output busy_res, output freed_count, input ready);
    modport sink (input valid, input status, input address, input hole_size,
                  input free_memory, input busy_res, input freed_count, output ready);
endinterface

>>> sv/bfsa_front.sv
// Front end: accepts requests, decodes the mode and queues them for the back end.
// Depends on bfsa_pkg and bfsa_intf.
module bfsa_front import bfsa_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    bfsa_in_if.sink         in_ch,
    output cmd_t            cmd,
    output logic            cmd_valid,
    input  logic            cmd_ready
);

    cmd_t       queue_reg [2];
    logic [1:0] count_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    cmd_t       decoded;
    logic       push;
    logic       pop;

    always_comb
    begin
        decoded.id   = in_ch.process_id;
        decoded.req  = in_ch.request_size;
        decoded.rt   = in_ch.run_time;
        decoded.tick = in_ch.tick_amount;
        case (in_ch.mode)
            MODE_ALLOC:   decoded.op = OP_ALLOC;
            MODE_FREE:    decoded.op = OP_FREE;
            MODE_TICK:    decoded.op = OP_TICK;
            MODE_COMPACT: decoded.op = OP_COMPACT;
            MODE_QUERY:   decoded.op = OP_QUERY;
            default:      decoded.op = OP_NONE;
        endcase
    end

    assign in_ch.ready = (count_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign cmd_valid   = (count_reg != 2'd0);
    assign pop         = cmd_valid && cmd_ready;
    assign cmd         = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                queue_reg[wr_ptr_reg] <= decoded;
                wr_ptr_reg            <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

>>> sv/bfsa_argmin.sv
// Two-stage minimum search over the segment start addresses.
// Depends on bfsa_pkg. The group minima are registered, so the result appears in the cycle after the inputs.
module bfsa_argmin import bfsa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  addr_vec_t              key,
    input  logic [MAX_ENTRIES-1:0] mask,
    output amin_t                  res
);

    amin_t grp_next [NGRP];
    amin_t grp_reg  [NGRP];

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int m = 0; m < 4; m++)
            begin
                if ((g * 4 + m) < MAX_ENTRIES)
                begin
                    if (mask[g * 4 + m] &&
                        (!grp_next[g].any || key[g * 4 + m] < grp_next[g].key))
                    begin
                        grp_next[g].any = 1'b1;
                        grp_next[g].idx = IDX_W'(g * 4 + m);
                        grp_next[g].key = key[g * 4 + m];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NGRP; g++)
            begin
                grp_reg[g] <= '0;
            end
        end
        else
        begin
            for (int g = 0; g < NGRP; g++)
            begin
                grp_reg[g] <= grp_next[g];
            end
        end
    end

    always_comb
    begin
        res = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            if (grp_reg[g].any && (!res.any || grp_reg[g].key < res.key))
            begin
                res = grp_reg[g];
            end
        end
    end

endmodule

>>> sv/bfsa_back.sv
// Back end: segment table, sequencer for all operations and the result register.
// Depends on bfsa_pkg, bfsa_intf and bfsa_argmin.
module bfsa_back import bfsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bfsa_cfg_if.sink  cfg,
    input  cmd_t      cmd,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    bfsa_out_if.source out_ch
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIT_A,
        S_FIT_B,
        S_FIT_END,
        S_TICK,
        S_CMP_A,
        S_CMP_B,
        S_FINISH
    } state_t;

    state_t                 state_reg;
    cmd_t                   cmd_reg;
    logic [ADDR_BITS-1:0]   cap_reg;
    logic [ADDR_BITS-1:0]   free_total_reg;
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [ID_W-1:0]        owner_reg  [MAX_ENTRIES];
    addr_vec_t              start_reg;
    logic [ADDR_BITS-1:0]   length_reg [MAX_ENTRIES];
    logic [TIME_W-1:0]      remain_reg [MAX_ENTRIES];

    logic [KCNT_W-1:0]      k_reg;
    logic [MAX_ENTRIES-1:0] done_reg;
    logic [ADDR_BITS-1:0]   cursor_reg;
    logic [ADDR_BITS-1:0]   cand_reg;
    logic                   cand_ok_reg;
    logic                   best_any_reg;
    logic [ADDR_BITS-1:0]   best_size_reg;
    logic [ADDR_BITS-1:0]   best_addr_reg;
    logic                   dup_reg;
    logic [IDX_W-1:0]       slot_reg;
    status_t                status_reg;
    logic [ADDR_BITS-1:0]   addr_reg;
    logic [ADDR_BITS-1:0]   hole_reg;
    logic [CNT_W-1:0]       freed_reg;

    logic                   res_valid_reg;
    status_t                res_status_reg;
    logic [ADDR_BITS-1:0]   res_addr_reg;
    logic [ADDR_BITS-1:0]   res_hole_reg;
    logic [ADDR_BITS-1:0]   res_free_reg;
    logic                   res_busy_reg;
    logic [FREED_W-1:0]     res_freed_reg;

    logic                   owner_hit;
    logic [IDX_W-1:0]       owner_idx;
    logic                   slot_free;
    logic [IDX_W-1:0]       free_idx;
    logic [KCNT_W-1:0]      k_minus1;
    logic [IDX_W-1:0]       k_idx;
    logic [ADDR_BITS-1:0]   cand;
    logic [MAX_ENTRIES-1:0] search_mask;
    amin_t                  amin;
    logic [ADDR_BITS-1:0]   next_start;
    logic [ADDR_BITS-1:0]   gap;
    logic [IDX_W-1:0]       tick_idx;
    logic                   cmd_take;

    assign cfg.ready  = 1'b1;
    assign cmd_ready  = (state_reg == S_IDLE) && !res_valid_reg;
    assign cmd_take   = cmd_valid && cmd_ready;

    assign out_ch.valid       = res_valid_reg;
    assign out_ch.status      = res_status_reg;
    assign out_ch.address     = res_addr_reg;
    assign out_ch.hole_size   = res_hole_reg;
    assign out_ch.free_memory = res_free_reg;
    assign out_ch.busy_res    = res_busy_reg;
    assign out_ch.freed_count = res_freed_reg;

    // Owner lookup and first free slot, both lowest index first.
    always_comb
    begin
        owner_hit = 1'b0;
        owner_idx = '0;
        slot_free = 1'b0;
        free_idx  = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && owner_reg[i] == cmd.id)
            begin
                owner_hit = 1'b1;
                owner_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                slot_free = 1'b1;
                free_idx  = IDX_W'(i);
            end
        end
    end

    // Hole candidates are address zero and the end of every segment; the hole
    // runs to the lowest segment start at or above it, or to the capacity.
    assign k_minus1 = k_reg - KCNT_W'(1);
    assign k_idx    = k_minus1[IDX_W-1:0];
    assign cand     = (k_reg == '0) ? '0 : start_reg[k_idx] + length_reg[k_idx];
    assign tick_idx = k_reg[IDX_W-1:0];

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (state_reg == S_CMP_A)
            begin
                search_mask[i] = valid_reg[i] && !done_reg[i];
            end
            else
            begin
                search_mask[i] = valid_reg[i] && (start_reg[i] >= cand);
            end
        end
    end

    bfsa_argmin u_argmin
    (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (start_reg),
        .mask  (search_mask),
        .res   (amin)
    );

    assign next_start = amin.any ? amin.key : cap_reg;
    assign gap        = next_start - cand_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cap_reg        <= '0;
            free_total_reg <= '0;
            valid_reg      <= '0;
            res_valid_reg  <= 1'b0;
            k_reg          <= '0;
            done_reg       <= '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg.valid && cfg.ready)
            begin
                cap_reg        <= cfg.data;
                free_total_reg <= cfg.data;
                valid_reg      <= '0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        cmd_reg       <= cmd;
                        status_reg    <= ST_OK;
                        addr_reg      <= '0;
                        hole_reg      <= '0;
                        freed_reg     <= '0;
                        k_reg         <= '0;
                        done_reg      <= '0;
                        cursor_reg    <= '0;
                        best_any_reg  <= 1'b0;
                        dup_reg       <= owner_hit;
                        slot_reg      <= free_idx;
                        state_reg     <= S_FINISH;
                        case (cmd.op)
                            OP_ALLOC:
                            begin
                                if (owner_hit)
                                begin
                                    status_reg <= ST_DUP;
                                end
                                else if (!slot_free)
                                begin
                                    status_reg <= ST_FULL;
                                end
                                else if (cmd.req == '0)
                                begin
                                    status_reg <= ST_NOFIT;
                                end
                                else
                                begin
                                    state_reg <= S_FIT_A;
                                end
                            end
                            OP_QUERY:
                            begin
                                if (cmd.req == '0)
                                begin
                                    status_reg <= owner_hit ? ST_DUP : ST_NOFIT;
                                end
                                else
                                begin
                                    state_reg <= S_FIT_A;
                                end
                            end
                            OP_FREE:
                            begin
                                if (owner_hit)
                                begin
                                    valid_reg[owner_idx] <= 1'b0;
                                    free_total_reg <= free_total_reg + length_reg[owner_idx];
                                end
                                else
                                begin
                                    status_reg <= ST_NOTFOUND;
                                end
                            end
                            OP_TICK:    state_reg <= S_TICK;
                            OP_COMPACT: state_reg <= S_CMP_A;
                            default:    state_reg <= S_FINISH;
                        endcase
                    end
                end
                S_FIT_A:
                begin
                    cand_reg    <= cand;
                    cand_ok_reg <= (k_reg == '0) || valid_reg[k_idx];
                    state_reg   <= S_FIT_B;
                end
                S_FIT_B:
                begin
                    // Candidates arrive in slot order; equal sizes fall back to
                    // the lower start address.
                    if (cand_ok_reg && next_start > cand_reg && gap >= cmd_reg.req &&
                        (!best_any_reg || gap < best_size_reg ||
                         (gap == best_size_reg && cand_reg < best_addr_reg)))
                    begin
                        best_any_reg  <= 1'b1;
                        best_size_reg <= gap;
                        best_addr_reg <= cand_reg;
                    end
                    if (k_reg == KCNT_W'(MAX_ENTRIES))
                    begin
                        state_reg <= S_FIT_END;
                    end
                    else
                    begin
                        k_reg     <= k_reg + KCNT_W'(1);
                        state_reg <= S_FIT_A;
                    end
                end
                S_FIT_END:
                begin
                    state_reg <= S_FINISH;
                    if (cmd_reg.op == OP_ALLOC)
                    begin
                        if (best_any_reg)
                        begin
                            valid_reg[slot_reg]  <= 1'b1;
                            owner_reg[slot_reg]  <= cmd_reg.id;
                            start_reg[slot_reg]  <= best_addr_reg;
                            length_reg[slot_reg] <= cmd_reg.req;
                            remain_reg[slot_reg] <= cmd_reg.rt;
                            free_total_reg       <= free_total_reg - cmd_reg.req;
                            addr_reg             <= best_addr_reg;
                        end
                        else
                        begin
                            status_reg <= ST_NOFIT;
                        end
                    end
                    else
                    begin
                        hole_reg <= best_any_reg ? best_size_reg : '0;
                        if (dup_reg)
                        begin
                            status_reg <= ST_DUP;
                        end
                        else if (!best_any_reg)
                        begin
                            status_reg <= ST_NOFIT;
                        end
                    end
                end
                S_TICK:
                begin
                    if (valid_reg[tick_idx])
                    begin
                        if (remain_reg[tick_idx] <= cmd_reg.tick)
                        begin
                            remain_reg[tick_idx] <= '0;
                            valid_reg[tick_idx]  <= 1'b0;
                            free_total_reg <= free_total_reg + length_reg[tick_idx];
                            freed_reg      <= freed_reg + CNT_W'(1);
                        end
                        else
                        begin
                            remain_reg[tick_idx] <= remain_reg[tick_idx] - cmd_reg.tick;
                        end
                    end
                    if (k_reg == KCNT_W'(MAX_ENTRIES - 1))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        k_reg <= k_reg + KCNT_W'(1);
                    end
                end
                S_CMP_A:
                begin
                    state_reg <= S_CMP_B;
                end
                S_CMP_B:
                begin
                    if (amin.any)
                    begin
                        start_reg[amin.idx] <= cursor_reg;
                        cursor_reg          <= cursor_reg + length_reg[amin.idx];
                        done_reg[amin.idx]  <= 1'b1;
                        state_reg           <= S_CMP_A;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    res_valid_reg  <= 1'b1;
                    res_status_reg <= status_reg;
                    res_addr_reg   <= addr_reg;
                    res_hole_reg   <= hole_reg;
                    res_free_reg   <= free_total_reg;
                    res_busy_reg   <= |valid_reg;
                    res_freed_reg  <= FREED_W'(freed_reg);
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/best_fit_segment_allocator_top.sv
// Top level of the best-fit segment allocator: front queue plus back-end sequencer.
// Depends on bfsa_pkg, bfsa_intf, bfsa_front and bfsa_back.
//
//  Channel   Dir   Transfer when       Carries
//  cfg       in    cfg.valid & ready   capacity (clears the segment table)
//  in_ch     in    valid & ready       mode, process_id, request_size, run_time, tick_amount
//  out_ch    out   valid & ready       status, address, hole_size, free_memory, busy_res,
//                                      freed_count
//
// Allocate and query visit the hole candidates in turn: each hole candidate passes
// through the two-stage minimum search over the segment starts.
// Advance time visits the table one slot per cycle; compact moves the live segments
// down one by one in start order; free and the other modes go straight to the result.
// Reset is asynchronous and active low and leaves an empty table with zero capacity.
// A two-entry queue takes requests while the back end works or its result waits.
module best_fit_segment_allocator_top import bfsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bfsa_cfg_if.sink    cfg,
    bfsa_in_if.sink     in_ch,
    bfsa_out_if.source  out_ch
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    bfsa_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    bfsa_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .out_ch    (out_ch)
    );

endmodule

>>> tb/sv/best_fit_segment_allocator_top_tb.sv
// Self-checking testbench for the best-fit segment allocator top level.
// Depends on bfsa_pkg, bfsa_intf and best_fit_segment_allocator_top.
`timescale 1ns / 1ps

module best_fit_segment_allocator_top_tb;
    import bfsa_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [ADDR_BITS-1:0] address;
        logic [ADDR_BITS-1:0] hole_size;
        logic [ADDR_BITS-1:0] free_memory;
        logic                 busy_res;
        logic [FREED_W-1:0]   freed_count;
    } alloc_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bfsa_cfg_if cfg();
    bfsa_in_if  in_ch();
    bfsa_out_if out_ch();

    best_fit_segment_allocator_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #2 clk = ~clk;

    // Shadow copy of the segment table.
    logic                 seg_live [MAX_ENTRIES];
    logic [ID_W-1:0]      seg_id   [MAX_ENTRIES];
    logic [ADDR_BITS-1:0] seg_base [MAX_ENTRIES];
    logic [ADDR_BITS-1:0] seg_len  [MAX_ENTRIES];
    logic [TIME_W-1:0]    seg_life [MAX_ENTRIES];
    logic [ADDR_BITS-1:0] mem_capacity;
    logic [ADDR_BITS-1:0] mem_free;

    alloc_result_t expected_results[$];
    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    bit recv_hold;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int live_in_address_order(output int ord[MAX_ENTRIES]);
        int n;
        int j;
        n = 0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (seg_live[i])
            begin
                j = n;
                while (j > 0 && seg_base[ord[j-1]] > seg_base[i])
                begin
                    ord[j] = ord[j-1];
                    j--;
                end
                ord[j] = i;
                n++;
            end
        end
        return n;
    endfunction

    function automatic bit smallest_fitting_hole(input logic [ADDR_BITS-1:0] req,
                                                 output logic [ADDR_BITS-1:0] haddr,
                                                 output logic [ADDR_BITS-1:0] hsize);
        int ord[MAX_ENTRIES];
        int n;
        logic [ADDR_BITS-1:0] cursor;
        logic [ADDR_BITS-1:0] nxt;
        logic [ADDR_BITS-1:0] gap;
        logic [ADDR_BITS-1:0] seg_end;
        bit found;
        n = live_in_address_order(ord);
        cursor = '0;
        found = 1'b0;
        haddr = '0;
        hsize = '0;
        for (int k = 0; k <= n; k++) begin
            nxt = (k < n) ? seg_base[ord[k]] : mem_capacity;
            if (nxt > cursor)
            begin
                gap = nxt - cursor;
                if (gap >= req && (!found || gap < hsize))
                begin
                    found = 1'b1;
                    hsize = gap;
                    haddr = cursor;
                end
            end
            if (k < n)
            begin
                seg_end = seg_base[ord[k]] + seg_len[ord[k]];
                if (seg_end > cursor)
                    cursor = seg_end;
            end
        end
        return found;
    endfunction

    function automatic int owner_slot(input logic [ID_W-1:0] id);
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (seg_live[i] && seg_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void clear_table(input logic [ADDR_BITS-1:0] cap);
        for (int i = 0; i < MAX_ENTRIES; i++)
            seg_live[i] = 1'b0;
        mem_capacity = cap;
        mem_free = cap;
    endfunction

    function automatic alloc_result_t predict_allocator(input logic [MODE_W-1:0] mode,
            input logic [ID_W-1:0] id, input logic [ADDR_BITS-1:0] req,
            input logic [TIME_W-1:0] rt, input logic [TIME_W-1:0] tick);
        alloc_result_t r;
        int spare;
        int ord[MAX_ENTRIES];
        int n;
        int idx;
        bit fits;
        logic [ADDR_BITS-1:0] haddr;
        logic [ADDR_BITS-1:0] hsize;
        logic [ADDR_BITS-1:0] cursor;
        r = '0;
        r.status = ST_OK;
        case (mode)
            MODE_ALLOC:
            begin
                spare = -1;
                for (int i = MAX_ENTRIES - 1; i >= 0; i--)
                    if (!seg_live[i])
                        spare = i;
                if (owner_slot(id) >= 0)
                    r.status = ST_DUP;
                else if (spare < 0)
                    r.status = ST_FULL;
                else if (req == 0 || !smallest_fitting_hole(req, haddr, hsize))
                    r.status = ST_NOFIT;
                else
                begin
                    seg_live[spare] = 1'b1;
                    seg_id[spare] = id;
                    seg_base[spare] = haddr;
                    seg_len[spare] = req;
                    seg_life[spare] = rt;
                    mem_free = mem_free - req;
                    r.address = haddr;
                end
            end
            MODE_FREE:
            begin
                idx = owner_slot(id);
                if (idx < 0)
                    r.status = ST_NOTFOUND;
                else
                begin
                    seg_live[idx] = 1'b0;
                    mem_free = mem_free + seg_len[idx];
                end
            end
            MODE_TICK:
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (seg_live[i])
                    begin
                        if (seg_life[i] <= tick)
                        begin
                            seg_life[i] = '0;
                            seg_live[i] = 1'b0;
                            mem_free = mem_free + seg_len[i];
                            r.freed_count++;
                        end
                        else
                            seg_life[i] = seg_life[i] - tick;
                    end
                end
            MODE_COMPACT:
            begin
                n = live_in_address_order(ord);
                cursor = '0;
                for (int k = 0; k < n; k++) begin
                    seg_base[ord[k]] = cursor;
                    cursor = cursor + seg_len[ord[k]];
                end
            end
            MODE_QUERY:
            begin
                fits = (req != 0) && smallest_fitting_hole(req, haddr, hsize);
                if (fits)
                    r.hole_size = hsize;
                if (owner_slot(id) >= 0)
                    r.status = ST_DUP;
                else if (!fits)
                    r.status = ST_NOFIT;
            end
            default: ;
        endcase
        r.free_memory = mem_free;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (seg_live[i])
                r.busy_res = 1'b1;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer with
    // valid still high, so a following request can drive it again in the same step.
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                                input logic [ADDR_BITS-1:0] req,
                                input logic [TIME_W-1:0] rt, input logic [TIME_W-1:0] tick);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.process_id <= id;
        in_ch.request_size <= req;
        in_ch.run_time <= rt;
        in_ch.tick_amount <= tick;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_results.push_back(predict_allocator(mode, id, req, rt, tick));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [ADDR_BITS-1:0] cap);
        wait_drained();
        cfg.valid <= 1'b1;
        cfg.data <= cap;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        clear_table(cap);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Receiver: random stalls, plus an optional long hold-off.
    always @(negedge clk) begin
        out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        alloc_result_t got;
        alloc_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.status, out_ch.address, out_ch.hole_size, out_ch.free_memory,
                    out_ch.busy_res, out_ch.freed_count};
            if (expected_results.size() == 0)
                report_mismatch("result transfer with nothing expected");
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
                if (got.address !== want.address)
                    report_mismatch($sformatf("address %0h want %0h", got.address,
                                              want.address));
                if (got.hole_size !== want.hole_size)
                    report_mismatch($sformatf("hole_size %0h want %0h", got.hole_size,
                                              want.hole_size));
                if (got.free_memory !== want.free_memory)
                    report_mismatch($sformatf("free_memory %0h want %0h", got.free_memory,
                                              want.free_memory));
                if (got.busy_res !== want.busy_res)
                    report_mismatch($sformatf("busy_res %0b want %0b", got.busy_res,
                                              want.busy_res));
                if (got.freed_count !== want.freed_count)
                    report_mismatch($sformatf("freed_count %0d want %0d", got.freed_count,
                                              want.freed_count));
            end
        end
    end

    task automatic test_directed();
        write_capacity(20'hFFFFF);
        send_request(MODE_QUERY, 16'h0000, 20'd0, 24'd0, 24'd0);
        send_request(MODE_ALLOC, 16'h0000, 20'd0, 24'd5, 24'd0);
        send_request(MODE_ALLOC, 16'hFFFF, 20'hFFFFF, 24'hFFFFFF, 24'd0);
        send_request(MODE_ALLOC, 16'h0001, 20'd1, 24'd1, 24'd0);
        send_request(MODE_FREE, 16'hFFFF, 20'd0, 24'd0, 24'd0);
        send_request(MODE_FREE, 16'hFFFF, 20'd0, 24'd0, 24'd0);
        write_capacity(20'd100);
        for (int i = 0; i < 5; i++)
            send_request(MODE_ALLOC, 16'(i), 20'(10 + 5 * i), 24'(i), 24'd0);
        send_request(MODE_ALLOC, 16'd2, 20'd5, 24'd3, 24'd0);
        send_request(MODE_FREE, 16'd1, 20'd0, 24'd0, 24'd0);
        send_request(MODE_FREE, 16'd3, 20'd0, 24'd0, 24'd0);
        send_request(MODE_QUERY, 16'd2, 20'd12, 24'd0, 24'd0);
        send_request(MODE_ALLOC, 16'd9, 20'd12, 24'd7, 24'd0);
        send_request(MODE_TICK, 16'd0, 20'd0, 24'd0, 24'd0);
        send_request(MODE_COMPACT, 16'd0, 20'd0, 24'd0, 24'd0);
        send_request(3'd5, 16'd0, 20'd0, 24'd0, 24'd0);
        send_request(3'd7, 16'hFFFF, 20'hFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_request(MODE_TICK, 16'd0, 20'd0, 24'd0, 24'hFFFFFF);
        write_capacity(20'd0);
        send_request(MODE_ALLOC, 16'd1, 20'd1, 24'd1, 24'd0);
        // Fill the table to reach the full-table status.
        write_capacity(20'd64);
        for (int i = 0; i < MAX_ENTRIES + 1; i++)
            send_request(MODE_ALLOC, 16'(i), 20'd1, 24'd9, 24'd0);
    endtask

    task automatic random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            send_request(MODE_ALLOC, 16'($urandom_range(23)),
                         ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(60)),
                         ($urandom_range(5) == 0) ? 24'($urandom) : 24'($urandom_range(40)),
                         24'($urandom));
        else if (pick < 60)
            send_request(MODE_FREE, ($urandom_range(9) == 0) ? 16'($urandom)
                         : 16'($urandom_range(23)), 20'($urandom), 24'($urandom),
                         24'($urandom));
        else if (pick < 72)
            send_request(MODE_TICK, 16'($urandom), 20'($urandom), 24'($urandom),
                         ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(8)));
        else if (pick < 80)
            send_request(MODE_COMPACT, 16'($urandom), 20'($urandom), 24'($urandom),
                         24'($urandom));
        else if (pick < 95)
            send_request(MODE_QUERY, 16'($urandom_range(23)),
                         ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(60)),
                         24'($urandom), 24'($urandom));
        else
            send_request(3'($urandom_range(7)), 16'($urandom), 20'($urandom),
                         24'($urandom), 24'($urandom));
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input logic [ADDR_BITS-1:0] cap, input int count);
        write_capacity(cap);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            random_request();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        write_capacity(20'd300);
        recv_hold = 1'b1;
        fork
            begin
                repeat (400) @(negedge clk);
                recv_hold = 1'b0;
            end
            for (int i = 0; i < 20; i++)
                random_request();
        join
    endtask

    initial begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        clear_table('0);
        cfg.valid = 1'b0;
        cfg.data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = '0;
        in_ch.process_id = '0;
        in_ch.request_size = '0;
        in_ch.run_time = '0;
        in_ch.tick_amount = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_phase(0, 0, 20'd200, 250);
        test_random_phase(64, 0, 20'd120, 200);
        test_random_phase(0, 64, 20'd400, 200);
        test_random_phase(7, 7, 20'($urandom), 250);
        test_backpressure();
        wait_drained();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
sv/bfsa_pkg.sv
sv/bfsa_intf.sv
sv/bfsa_front.sv
sv/bfsa_argmin.sv
sv/bfsa_back.sv
sv/best_fit_segment_allocator_top.sv
tb/sv/best_fit_segment_allocator_top_tb.sv
